// ----- hdl/serial_line_unit_registers_assert.svh -----
// assertion macros for the serial line unit rtl
// both sample on i_clk and are quiet while i_rst_n is low
`ifndef SERIAL_LINE_UNIT_REGISTERS_ASSERT_SVH
`define SERIAL_LINE_UNIT_REGISTERS_ASSERT_SVH

// condition holds at every clock edge
`define SLU_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define SLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/slu_pkg.sv -----
package slu_pkg;

    typedef logic [2:0] t_req;
    typedef logic [1:0] t_off;
    // receive buffer error nibble: parity, framing, overrun, any error
    typedef logic [3:0] t_err;

    // request kinds
    localparam t_req REQ_READ    = 3'd0;
    localparam t_req REQ_WRITE   = 3'd1;
    localparam t_req REQ_RX_CHAR = 3'd2;
    localparam t_req REQ_TX_DONE = 3'd3;
    localparam t_req REQ_RESET   = 3'd4;

    // register words
    localparam t_off OFF_RX_STAT = 2'd0;
    localparam t_off OFF_RX_BUF  = 2'd1;
    localparam t_off OFF_TX_STAT = 2'd2;
    localparam t_off OFF_TX_BUF  = 2'd3;

    // error nibble positions and patterns
    localparam int   ERR_ANY        = 3;
    localparam t_err ERR_NONE       = 4'b0000;
    localparam t_err ERR_BREAK      = 4'b1011;
    localparam t_err ERR_OVERRUN    = 4'b1100;

    // status bit positions within a 16-bit word
    localparam int   BIT_READER_EN  = 0;
    localparam int   BIT_BREAK      = 0;
    localparam int   BIT_MAINT      = 2;
    localparam int   BIT_IE         = 6;

endpackage

// ----- hdl/serial_line_unit_registers.sv -----
// register model of an asynchronous serial line unit
// input channel (i_in_valid / o_in_ready) carries one bus access or line event
// per item: bus read, bus write, received character, transmit done, or reset
// output channel (o_out_valid / i_out_ready) returns exactly one result item
// per input item: read word, transmitted character and both interrupt levels
// the item is held in an input register, then one pass of logic updates the
// registers and fills the result register, which drives the outputs; one item
// is taken every cycle while the receiver takes each result
// the input register and result register form two stages, so the block keeps
// accepting while a result waits; when the receiver stalls with both stages
// full o_in_ready drops until the result is taken
// the receive fifo is a shift line with its head at entry zero
// i_rst_n (synchronous, active low) restores ready transmit status, empty
// fifo, cleared interrupt requests and maintenance support enabled; no
// clearing pass is needed, the fifo is valid only below its fill count
// i_cfg_wr_en with i_cfg_wr_data sets the maintenance-supported flag
`include "serial_line_unit_registers_assert.svh"

module serial_line_unit_registers
    import slu_pkg::*;
#(
    parameter int RX_FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [1:0]  i_reg_offset,
    input  logic [15:0] i_write_data,
    input  logic [7:0]  i_rx_char,
    input  logic        i_rx_break,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_read_data,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_char,
    output logic        o_rx_irq,
    output logic        o_tx_irq
);

    localparam int CNT_W = $clog2(RX_FIFO_DEPTH + 1);
    localparam int IDX_W = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam logic [CNT_W-1:0] RX_FULL = CNT_W'(RX_FIFO_DEPTH);

    // configuration
    logic r_maint_sup;

    // input stage
    logic        r_in_valid;
    t_req        r_in_req;
    t_off        r_in_off;
    logic [15:0] r_in_wdata;
    logic [7:0]  r_in_rx_char;
    logic        r_in_rx_break;

    // result stage
    logic        r_out_valid;
    logic [15:0] r_read_data;
    logic        r_tx_valid;
    logic [7:0]  r_tx_char;

    // register state
    logic             r_rx_ie,    n_rx_ie;
    logic             r_rx_done,  n_rx_done;
    t_err             r_rx_err,   n_rx_err;
    logic [7:0]       r_rx_data,  n_rx_data;
    logic             r_ts_brk,   n_ts_brk;
    logic             r_ts_maint, n_ts_maint;
    logic             r_ts_ie,    n_ts_ie;
    logic             r_ts_ready, n_ts_ready;
    logic [7:0]       r_holding,  n_holding;
    logic             r_pending,  n_pending;
    logic             r_rx_irq,   n_rx_irq;
    logic             r_tx_irq,   n_tx_irq;
    logic [CNT_W-1:0] r_rx_count, n_rx_count;
    logic [8:0]       r_fifo [RX_FIFO_DEPTH];
    logic [8:0]       n_fifo [RX_FIFO_DEPTH];

    // per-item controls
    logic             advance;
    logic             fifo_get;
    logic             fifo_put;
    logic [IDX_W-1:0] put_idx;
    logic [8:0]       put_data;
    logic             rcv;
    logic [7:0]       rcv_char;
    logic             rcv_brk;
    logic [15:0]      n_read_data;
    logic             n_tx_valid;
    logic [7:0]       n_tx_char;

    // handshake: the input stage moves on when the result stage is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || !r_out_valid || i_out_ready;

    // single pass over the item in the input register
    always_comb begin
        n_rx_ie     = r_rx_ie;
        n_rx_done   = r_rx_done;
        n_rx_err    = r_rx_err;
        n_rx_data   = r_rx_data;
        n_ts_brk    = r_ts_brk;
        n_ts_maint  = r_ts_maint;
        n_ts_ie     = r_ts_ie;
        n_ts_ready  = r_ts_ready;
        n_holding   = r_holding;
        n_pending   = r_pending;
        n_rx_irq    = r_rx_irq;
        n_tx_irq    = r_tx_irq;
        n_rx_count  = r_rx_count;
        fifo_get    = 1'b0;
        fifo_put    = 1'b0;
        put_idx     = '0;
        put_data    = '0;
        rcv         = 1'b0;
        rcv_char    = r_in_rx_char;
        rcv_brk     = r_in_rx_break;
        n_read_data = '0;
        n_tx_valid  = 1'b0;
        n_tx_char   = '0;

        case (r_in_req)
            REQ_READ: begin
                case (r_in_off)
                    OFF_RX_STAT: begin
                        n_read_data = {8'h00, r_rx_done, r_rx_ie, 6'b000000};
                    end
                    OFF_RX_BUF: begin
                        // pop the fifo head into the buffer word
                        if (r_rx_count != '0) begin
                            n_rx_data  = r_fifo[0][7:0];
                            fifo_get   = 1'b1;
                            n_rx_count = r_rx_count - CNT_W'(1);
                            n_rx_done  = 1'b0;
                        end
                        n_rx_irq    = 1'b0;
                        n_read_data = {n_rx_err, 4'b0000, n_rx_data};
                    end
                    OFF_TX_STAT: begin
                        n_read_data = {8'h00, r_ts_ready, r_ts_ie, 3'b000,
                                       r_ts_maint, 1'b0, r_ts_brk};
                    end
                    default: begin
                        n_read_data = {8'h00, r_holding};
                    end
                endcase
            end
            REQ_WRITE: begin
                case (r_in_off)
                    OFF_RX_STAT: begin
                        n_rx_ie = r_in_wdata[BIT_IE];
                        if (r_in_wdata[BIT_IE] && !r_rx_ie && r_rx_done) begin
                            n_rx_irq = 1'b1;
                        end
                        if (r_rx_ie && !r_in_wdata[BIT_IE]) begin
                            n_rx_irq = 1'b0;
                        end
                        // reader enable flushes the fifo
                        if (r_in_wdata[BIT_READER_EN]) begin
                            n_rx_count = '0;
                            n_rx_done  = 1'b0;
                        end
                    end
                    OFF_TX_STAT: begin
                        n_ts_brk = r_in_wdata[BIT_BREAK];
                        n_ts_ie  = r_in_wdata[BIT_IE];
                        if (r_maint_sup) begin
                            n_ts_maint = r_in_wdata[BIT_MAINT];
                        end
                        // break queues a zero character, ready is left as it is
                        if (r_in_wdata[BIT_BREAK]) begin
                            n_holding = '0;
                            n_pending = 1'b1;
                        end
                        if (r_in_wdata[BIT_IE] && !r_ts_ie && n_ts_ready) begin
                            n_tx_irq = 1'b1;
                        end
                        if (r_ts_ie && !r_in_wdata[BIT_IE]) begin
                            n_tx_irq = 1'b0;
                        end
                    end
                    OFF_TX_BUF: begin
                        n_tx_irq = 1'b0;
                        if (!r_ts_brk) begin
                            n_ts_ready = 1'b0;
                        end
                        n_holding = r_in_wdata[7:0];
                        n_pending = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            REQ_RX_CHAR: begin
                rcv = 1'b1;
            end
            REQ_TX_DONE: begin
                // maintenance bit doubles as the loopback flag
                if (r_pending) begin
                    n_pending  = 1'b0;
                    n_ts_ready = 1'b1;
                    if (!r_ts_maint) begin
                        n_tx_valid = 1'b1;
                        n_tx_char  = r_holding;
                    end
                    if (r_ts_ie) begin
                        n_tx_irq = 1'b1;
                    end
                    if (r_ts_maint) begin
                        rcv      = 1'b1;
                        rcv_char = r_holding;
                        rcv_brk  = r_ts_brk;
                    end
                end
            end
            REQ_RESET: begin
                n_rx_count = '0;
                n_rx_ie    = 1'b0;
                n_rx_done  = 1'b0;
                n_rx_err   = ERR_NONE;
                n_ts_brk   = 1'b0;
                n_ts_maint = 1'b0;
                n_ts_ie    = 1'b0;
                n_ts_ready = 1'b1;
                n_rx_irq   = 1'b0;
                n_tx_irq   = 1'b0;
            end
            default: begin
            end
        endcase

        // character into the receiver
        if (rcv) begin
            if (n_rx_err[ERR_ANY] && (n_rx_count == '0)) begin
                n_rx_err = ERR_NONE;
            end
            if (rcv_brk) begin
                n_rx_err = n_rx_err | ERR_BREAK;
            end
            fifo_put = 1'b1;
            put_data = {rcv_brk, rcv_char};
            if (n_rx_count != RX_FULL) begin
                put_idx    = n_rx_count[IDX_W-1:0];
                n_rx_count = n_rx_count + CNT_W'(1);
                n_rx_done  = 1'b1;
                if (n_rx_ie) begin
                    n_rx_irq = 1'b1;
                end
            end else begin
                // overrun: flush and keep only the new character
                n_rx_err   = ERR_OVERRUN;
                n_rx_data  = '0;
                put_idx    = '0;
                n_rx_count = CNT_W'(1);
            end
        end
    end

    // fifo shift line, head at entry zero
    for (genvar gi = 0; gi < RX_FIFO_DEPTH; gi++) begin : g_fifo
        if (gi < RX_FIFO_DEPTH - 1) begin : g_mid
            always_comb begin
                if (fifo_put && (put_idx == IDX_W'(gi))) begin
                    n_fifo[gi] = put_data;
                end else if (fifo_get) begin
                    n_fifo[gi] = r_fifo[gi + 1];
                end else begin
                    n_fifo[gi] = r_fifo[gi];
                end
            end
        end else begin : g_last
            always_comb begin
                if (fifo_put && (put_idx == IDX_W'(gi))) begin
                    n_fifo[gi] = put_data;
                end else begin
                    n_fifo[gi] = r_fifo[gi];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_fifo[gi] <= n_fifo[gi];
            end
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maint_sup <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_maint_sup <= i_cfg_wr_data;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req      <= i_req_type;
            r_in_off      <= i_reg_offset;
            r_in_wdata    <= i_write_data;
            r_in_rx_char  <= i_rx_char;
            r_in_rx_break <= i_rx_break;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data <= n_read_data;
            r_tx_valid  <= n_tx_valid;
            r_tx_char   <= n_tx_char;
        end
    end

    // register state, committed as the item moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_ie    <= 1'b0;
            r_rx_done  <= 1'b0;
            r_rx_err   <= ERR_NONE;
            r_rx_data  <= '0;
            r_ts_brk   <= 1'b0;
            r_ts_maint <= 1'b0;
            r_ts_ie    <= 1'b0;
            r_ts_ready <= 1'b1;
            r_holding  <= '0;
            r_pending  <= 1'b0;
            r_rx_irq   <= 1'b0;
            r_tx_irq   <= 1'b0;
            r_rx_count <= '0;
        end else if (advance) begin
            r_rx_ie    <= n_rx_ie;
            r_rx_done  <= n_rx_done;
            r_rx_err   <= n_rx_err;
            r_rx_data  <= n_rx_data;
            r_ts_brk   <= n_ts_brk;
            r_ts_maint <= n_ts_maint;
            r_ts_ie    <= n_ts_ie;
            r_ts_ready <= n_ts_ready;
            r_holding  <= n_holding;
            r_pending  <= n_pending;
            r_rx_irq   <= n_rx_irq;
            r_tx_irq   <= n_tx_irq;
            r_rx_count <= n_rx_count;
        end
    end

    // outputs
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_tx_valid  = r_tx_valid;
    assign o_tx_char   = r_tx_char;
    assign o_rx_irq    = r_rx_irq;
    assign o_tx_irq    = r_tx_irq;

    // assertions
    `SLU_ASSERT_NOW(a_count_in_range, (r_rx_count <= RX_FULL), "rx fifo count above depth")
    `SLU_ASSERT_NOW(a_done_has_char, (!r_rx_done || (r_rx_count != '0)), "done with empty fifo")
    `SLU_ASSERT_NOW(a_busy_has_char, (r_ts_ready || r_pending), "tx not ready with nothing pending")
    `SLU_ASSERT_NEXT(a_reset_flush, (advance && (r_in_req == REQ_RESET)), (r_rx_count == '0), "reset item left fifo filled")

endmodule
